/* rtl/core/gflq_pkg.sv */
// Package for the group favoring lock queue: codes, constants, state type
// and the command/status structs between controller and datapath.
// No dependencies.
package gflq_pkg;

    // Request kinds
    localparam logic [2:0] KIND_CREATE  = 3'd0;
    localparam logic [2:0] KIND_DESTROY = 3'd1;
    localparam logic [2:0] KIND_ENQUEUE = 3'd2;
    localparam logic [2:0] KIND_TAKE    = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;

    // Response status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_ERR  = 2'd1;
    localparam logic [1:0] STS_WAIT = 2'd2;

    localparam logic [6:0] FAVOR_MAX  = 7'd100;
    localparam logic [7:0] MOD_BASE   = 8'd100;
    localparam logic [8:0] GROUP_NONE = 9'h1FF;

    // Reciprocal of 100 scaled by 2^38; exact quotient for any 32-bit value
    localparam logic [31:0] MOD_RECIP = 32'd2748779070;
    localparam int          MOD_SHIFT = 38;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TAKE,
        ST_SCAN,
        ST_MOD,
        ST_FAVOR,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic decode;
        logic take_chk;
        logic scan_step;
        logic mod_step;
        logic shift_rd;
        logic shift_wr;
        logic put;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_fire;
        logic go_take;
        logic go_scan;
        logic scan_hit;
        logic scan_hit_zero;
        logic scan_more;
        logic mod_done;
        logic favor_ok;
        logic shift_last;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/gflq_if.sv */
// Request and response channel interfaces of the lock queue.
// Valid/ready handshake; no dependencies.
interface gflq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  lock_index;
    logic [6:0]  favor_percent;
    logic [15:0] requester_pid;
    logic [7:0]  requester_gid;
    logic [31:0] random_word;

    modport source (output valid, kind, lock_index, favor_percent, requester_pid,
                    requester_gid, random_word, input ready);
    modport sink (input valid, kind, lock_index, favor_percent, requester_pid,
                  requester_gid, random_word, output ready);
endinterface

interface gflq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] created_index;

    modport source (output valid, status, created_index, input ready);
    modport sink (input valid, status, created_index, output ready);
endinterface

/* rtl/core/gflq_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module gflq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 240
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/gflq_ctrl.sv */
// Controller state machine of the lock queue.
// Depends on gflq_pkg (state_t, cmd_t, sts_t).
module gflq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  gflq_pkg::sts_t sts,
    output gflq_pkg::cmd_t cmd
);
    gflq_pkg::state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gflq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            gflq_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_fire)
                begin
                    state_next = gflq_pkg::ST_DECODE;
                end
            end
            gflq_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.go_take)
                begin
                    state_next = gflq_pkg::ST_TAKE;
                end
                else if (sts.go_scan)
                begin
                    state_next = gflq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = gflq_pkg::ST_RESULT;
                end
            end
            gflq_pkg::ST_TAKE:
            begin
                cmd.take_chk = 1'b1;
                state_next   = gflq_pkg::ST_RESULT;
            end
            gflq_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = sts.scan_hit_zero ? gflq_pkg::ST_RESULT : gflq_pkg::ST_MOD;
                end
                else if (!sts.scan_more)
                begin
                    state_next = gflq_pkg::ST_RESULT;
                end
            end
            gflq_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = gflq_pkg::ST_FAVOR;
                end
            end
            gflq_pkg::ST_FAVOR:
            begin
                state_next = sts.favor_ok ? gflq_pkg::ST_SHIFT_RD : gflq_pkg::ST_RESULT;
            end
            gflq_pkg::ST_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = gflq_pkg::ST_SHIFT_WR;
            end
            gflq_pkg::ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = sts.shift_last ? gflq_pkg::ST_PUT : gflq_pkg::ST_SHIFT_RD;
            end
            gflq_pkg::ST_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = gflq_pkg::ST_RESULT;
            end
            gflq_pkg::ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = gflq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gflq_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

/* rtl/core/gflq_dp.sv */
// Datapath of the lock queue: request register, per-lock state, wait queue
// RAM, modulo-100 unit and response register. Depends on gflq_pkg, gflq_if,
// gflq_ram.
module gflq_dp #(
    parameter int NUM_LOCKS   = 15,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    gflq_req_if.sink       req,
    gflq_rsp_if.source     rsp,
    input  gflq_pkg::cmd_t cmd,
    output gflq_pkg::sts_t sts
);
    localparam int SW    = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = NUM_LOCKS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Request register
    logic [2:0]  kind_reg;
    logic [3:0]  lock_reg;
    logic [6:0]  favor_in_reg;
    logic [15:0] pid_reg;
    logic [7:0]  gid_reg;
    logic [31:0] rnd_reg;

    // Per-lock state
    logic [NUM_LOCKS-1:0] active_reg;
    logic [NUM_LOCKS-1:0] held_reg;
    logic [6:0]           favor_reg [NUM_LOCKS];
    logic [8:0]           group_reg [NUM_LOCKS];
    logic [HW-1:0]        head_reg  [NUM_LOCKS];
    logic [CW-1:0]        count_reg [NUM_LOCKS];

    // Scan, modulo and result state
    logic [HW-1:0] pos_reg;
    logic [23:0]   moved_reg;
    logic [6:0]    rem_reg;
    logic [25:0]   quot_reg;
    logic          mod_phase_reg;
    logic [1:0]    res_status_reg;
    logic [3:0]    res_created_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [3:0]    out_created_reg;

    logic [6:0]    lock_wide;
    logic          idx_ok;
    logic [SW-1:0] slot;
    logic          slot_ok;
    logic          held_cur;
    logic [CW-1:0] cnt_cur;
    logic [HW-1:0] head_cur;
    logic [AW-1:0] base;
    logic          free_any;
    logic [SW-1:0] free_idx;
    logic          room;
    logic          can_destroy;
    logic          take_match;
    logic          group_match;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_wdata, ram_rdata;

    function automatic logic [HW-1:0] qpos(input logic [HW-1:0] h, input logic [HW-1:0] o);
        logic [HW:0] sum;
        sum = {1'b0, h} + {1'b0, o};
        if (sum >= (HW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (HW+1)'(QUEUE_DEPTH);
        end
        return sum[HW-1:0];
    endfunction

    // Select the addressed lock
    assign lock_wide   = 7'(lock_reg);
    assign idx_ok      = lock_wide < 7'(NUM_LOCKS);
    assign slot        = idx_ok ? lock_wide[SW-1:0] : '0;
    assign slot_ok     = idx_ok && active_reg[slot];
    assign held_cur    = held_reg[slot];
    assign cnt_cur     = count_reg[slot];
    assign head_cur    = head_reg[slot];
    assign base        = AW'(slot) * AW'(QUEUE_DEPTH);
    assign room        = cnt_cur < CW'(QUEUE_DEPTH);
    assign can_destroy = !held_cur && (cnt_cur == '0);
    assign take_match  = ram_rdata[23:8] == pid_reg;
    assign group_match = {1'b0, ram_rdata[7:0]} == group_reg[slot];

    // Find the lowest free lock
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // Wait queue RAM access
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = base + AW'(qpos(head_cur, pos_reg));
        ram_wdata = ram_rdata;
        ram_raddr = base + AW'(head_cur);
        if (cmd.decode && kind_reg == gflq_pkg::KIND_ENQUEUE && slot_ok && room)
        begin
            ram_we    = 1'b1;
            ram_waddr = base + AW'(qpos(head_cur, HW'(cnt_cur)));
            ram_wdata = {pid_reg, gid_reg};
        end
        else if (cmd.shift_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.put)
        begin
            ram_we    = 1'b1;
            ram_waddr = base + AW'(head_cur);
            ram_wdata = moved_reg;
        end
        if (cmd.scan_step)
        begin
            ram_raddr = base + AW'(qpos(head_cur, pos_reg + 1'b1));
        end
        else if (cmd.shift_rd)
        begin
            ram_raddr = base + AW'(qpos(head_cur, pos_reg - 1'b1));
        end
    end

    gflq_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= '0;
            lock_reg     <= '0;
            favor_in_reg <= '0;
            pid_reg      <= '0;
            gid_reg      <= '0;
            rnd_reg      <= '0;
        end
        else if (sts.in_fire)
        begin
            kind_reg     <= req.kind;
            lock_reg     <= req.lock_index;
            favor_in_reg <= req.favor_percent;
            pid_reg      <= req.requester_pid;
            gid_reg      <= req.requester_gid;
            rnd_reg      <= req.random_word;
        end
    end

    // Update per-lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            held_reg   <= '0;
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                favor_reg[i] <= '0;
                group_reg[i] <= gflq_pkg::GROUP_NONE;
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.decode)
            begin
                case (kind_reg)
                    gflq_pkg::KIND_CREATE:
                    begin
                        if (favor_in_reg <= gflq_pkg::FAVOR_MAX && free_any)
                        begin
                            active_reg[free_idx] <= 1'b1;
                            held_reg[free_idx]   <= 1'b0;
                            favor_reg[free_idx]  <= favor_in_reg;
                            group_reg[free_idx]  <= gflq_pkg::GROUP_NONE;
                            head_reg[free_idx]   <= '0;
                            count_reg[free_idx]  <= '0;
                        end
                    end
                    gflq_pkg::KIND_DESTROY:
                    begin
                        if (slot_ok && can_destroy)
                        begin
                            active_reg[slot] <= 1'b0;
                        end
                    end
                    gflq_pkg::KIND_ENQUEUE:
                    begin
                        if (slot_ok && room)
                        begin
                            count_reg[slot] <= cnt_cur + 1'b1;
                        end
                    end
                    gflq_pkg::KIND_RELEASE:
                    begin
                        if (slot_ok && held_cur)
                        begin
                            held_reg[slot] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // Grant the lock and pop the head
            if (cmd.take_chk && take_match)
            begin
                held_reg[slot]  <= 1'b1;
                group_reg[slot] <= {1'b0, gid_reg};
                head_reg[slot]  <= qpos(head_cur, HW'(1));
                count_reg[slot] <= cnt_cur - 1'b1;
            end
        end
    end

    // Scan position, modulo unit and result
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            pos_reg         <= '0;
            rem_reg         <= '0;
            mod_phase_reg   <= 1'b0;
            res_created_reg <= '0;
            res_status_reg  <= gflq_pkg::STS_ERR;
            case (kind_reg)
                gflq_pkg::KIND_CREATE:
                begin
                    if (favor_in_reg <= gflq_pkg::FAVOR_MAX && free_any)
                    begin
                        res_status_reg  <= gflq_pkg::STS_OK;
                        res_created_reg <= 4'(free_idx);
                    end
                end
                gflq_pkg::KIND_DESTROY:
                begin
                    if (slot_ok && can_destroy)
                    begin
                        res_status_reg <= gflq_pkg::STS_OK;
                    end
                end
                gflq_pkg::KIND_ENQUEUE:
                begin
                    if (slot_ok && room)
                    begin
                        res_status_reg <= gflq_pkg::STS_OK;
                    end
                end
                gflq_pkg::KIND_TAKE:
                begin
                    if (slot_ok)
                    begin
                        res_status_reg <= gflq_pkg::STS_WAIT;
                    end
                end
                gflq_pkg::KIND_RELEASE:
                begin
                    if (slot_ok && held_cur)
                    begin
                        res_status_reg <= gflq_pkg::STS_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.take_chk && take_match)
        begin
            res_status_reg <= gflq_pkg::STS_OK;
        end
        if (cmd.scan_step)
        begin
            moved_reg <= ram_rdata;
            if (!group_match)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
        if (cmd.shift_wr)
        begin
            pos_reg <= pos_reg - 1'b1;
        end
        // Modulo 100: reciprocal multiply for the quotient, then subtract
        if (cmd.mod_step)
        begin
            if (!mod_phase_reg)
            begin
                quot_reg <= 26'((64'(rnd_reg) * 64'(gflq_pkg::MOD_RECIP))
                                >> gflq_pkg::MOD_SHIFT);
            end
            else
            begin
                rem_reg <= 7'(rnd_reg - 32'(quot_reg) * 32'(gflq_pkg::MOD_BASE));
            end
            mod_phase_reg <= !mod_phase_reg;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg  <= res_status_reg;
            out_created_reg <= res_created_reg;
        end
    end

    assign req.ready         = cmd.in_ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.created_index = out_created_reg;

    // Status to the controller
    always_comb
    begin
        sts               = '0;
        sts.in_fire       = req.valid && cmd.in_ready;
        sts.go_take       = kind_reg == gflq_pkg::KIND_TAKE && slot_ok && !held_cur
                            && cnt_cur != '0;
        sts.go_scan       = kind_reg == gflq_pkg::KIND_RELEASE && slot_ok && held_cur
                            && cnt_cur != '0;
        sts.scan_hit      = group_match;
        sts.scan_hit_zero = pos_reg == '0;
        sts.scan_more     = ((CW+1)'(pos_reg) + 1'b1) < (CW+1)'(cnt_cur);
        sts.mod_done      = mod_phase_reg;
        sts.favor_ok      = rem_reg < favor_reg[slot];
        sts.shift_last    = pos_reg == HW'(1);
        sts.out_free      = !out_valid_reg || rsp.ready;
    end

    // Queue fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_cur <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // Remainder stays reduced after every step
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.mod_step) |-> rem_reg < 7'(gflq_pkg::MOD_BASE))
        else $error("remainder not reduced");

    // A loaded response shows valid next cycle
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("response lost after load");

    // No new request while a response load is pending in the same cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.in_ready))
        else $error("request taken during response load");
endmodule

/* rtl/core/group_favoring_lock_queue.sv */
// Top level of the group favoring lock queue.
// Depends on gflq_pkg, gflq_if, gflq_ctrl, gflq_dp (and gflq_ram below it).
//
// Usage: requests enter on req (valid/ready), one response per request leaves
// on rsp (valid/ready). Kinds: create, destroy, enqueue waiter, try take,
// release. A blocked take answers "must wait"; the caller retries.
// One request is worked at a time; the next one is taken once the response
// is loaded into the output register, even while rsp is stalled.
// Steps per request from accept to response loaded (each ends in result):
//   create, destroy, enqueue: decode; try take: decode, take check;
//   release: decode and a scan of up to the queue length, then on a group hit
//   past the head a modulo-100 reduction (reciprocal multiply, subtract), a
//   favor compare, a read and a write per queue entry moved, and a put of the
//   hit at the head. The worst case is set by the single read port wait queue
//   RAM. The idle state comes before the next accept.
// Reset clears all lock slots (inactive, not held, empty queues) and the
// response valid flag; wait queue RAM entries need no clearing.
// A stalled rsp holds its response; a further request is then taken but its
// response waits in the result register until the output register frees.
module group_favoring_lock_queue #(
    parameter int NUM_LOCKS   = 15,
    parameter int QUEUE_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    gflq_req_if.sink   req,
    gflq_rsp_if.source rsp
);
    gflq_pkg::cmd_t cmd;
    gflq_pkg::sts_t sts;

    gflq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    gflq_dp #(
        .NUM_LOCKS   (NUM_LOCKS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );
endmodule
